// ===== sv/srtf_pkg.sv =====
// Shared types and constants for the SRTF tick scheduler.
package srtf_pkg;

  localparam int MaxProcsDef = 16;
  localparam int TimeBitsDef = 16;
  localparam int FieldW      = 16;
  localparam int CountW      = 5;
  localparam int CfgAddrW    = 3;
  localparam int CfgDataW    = 32;

  localparam logic [1:0] CMD_LOAD    = 2'd0;
  localparam logic [1:0] CMD_TICK    = 2'd1;
  localparam logic [1:0] CMD_RESTART = 2'd2;

  localparam logic REG_ACTIVE_COUNT = 1'b0;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_LAST,
    ST_UPDATE,
    ST_SWEEP,
    ST_SWEEP_END,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic [FieldW-1:0] arrival;
    logic [FieldW-1:0] burst;
    logic [FieldW-1:0] remaining;
  } slot_entry_t;

endpackage

// ===== sv/srtf_slot_ram.sv =====
// Process slot table: one write port, one registered read port.
module srtf_slot_ram
  import srtf_pkg::*;
#(
  parameter int DEPTH = MaxProcsDef
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  slot_entry_t              wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output slot_entry_t              rd_data
);

  slot_entry_t mem [DEPTH];
  slot_entry_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== sv/srtf_tick_scheduler.sv =====
// Shortest-remaining-time-first scheduler over a table of process slots.
//
// Input channel (in_valid / in_stall): a command beat carries cmd, slot,
// arrival and burst. A load writes one slot. A restart sweeps the slot
// table, one slot a cycle. A tick reads the active slots one per cycle
// from the slot memory, picks the least remaining time, updates that slot
// and yields one result beat; the scan covers the clamped active count
// through the single memory read port. A tick with every active slot done
// skips the scan.
// Result channel (out_valid / out_stall): the result sits in an output
// register; the block takes the next command while it waits, and a second
// result holds in ST_EMIT until the first one has left.
// APB port: register 0 is active_count (5 bits, reads back).
// Reset clears time, done flags, active_count to 1 and the channels; slot
// contents stay undefined until loaded.
module srtf_tick_scheduler
  import srtf_pkg::*;
#(
  parameter int MAX_PROCS = MaxProcsDef,
  parameter int TIME_BITS = TimeBitsDef
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [1:0]          in_cmd,
  input  logic [3:0]          in_slot,
  input  logic [FieldW-1:0]   in_arrival,
  input  logic [FieldW-1:0]   in_burst,
  output logic                out_valid,
  input  logic                out_stall,
  output logic                out_idle,
  output logic [3:0]          out_proc_index,
  output logic                out_finished,
  output logic [FieldW-1:0]   out_completion_time,
  output logic [FieldW-1:0]   out_turnaround,
  output logic [FieldW-1:0]   out_waiting,
  output logic                out_all_done,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [CfgAddrW-1:0] paddr,
  input  logic [CfgDataW-1:0] pwdata,
  output logic [CfgDataW-1:0] prdata,
  output logic                pready
);

  localparam int IW = $clog2(MAX_PROCS);
  localparam int CW = (TIME_BITS > FieldW) ? TIME_BITS : FieldW;
  localparam int NW = $clog2(MAX_PROCS + 1);
  localparam int LW = (NW > CountW) ? NW : CountW;

  state_t state_r, state_nxt;

  logic [CountW-1:0]    active_count_r;
  logic [TIME_BITS-1:0] time_r;
  logic [MAX_PROCS-1:0] done_r;
  logic [IW-1:0]        issue_idx_r;
  logic                 rd_vld_r;
  logic [IW-1:0]        rd_idx_r;

  logic                 found_r;
  logic [IW-1:0]        best_idx_r;
  logic [FieldW-1:0]    best_arr_r;
  logic [FieldW-1:0]    best_bur_r;
  logic [FieldW-1:0]    best_rem_r;

  logic                 res_idle_r;
  logic [IW-1:0]        res_proc_r;
  logic                 res_fin_r;
  logic [FieldW-1:0]    res_ct_r;
  logic [CW-1:0]        res_tat_r;
  logic [FieldW-1:0]    res_bur_r;

  logic                 out_valid_r;
  logic                 out_idle_r;
  logic [3:0]           out_proc_r;
  logic                 out_fin_r;
  logic [FieldW-1:0]    out_ct_r;
  logic [FieldW-1:0]    out_tat_r;
  logic [FieldW-1:0]    out_wt_r;
  logic                 out_all_done_r;

  // active slot range
  logic [LW-1:0]        ac_ext;
  logic [LW-1:0]        live_last;
  logic [IW-1:0]        last_idx;
  logic [MAX_PROCS-1:0] act_mask;
  logic                 all_done_now;

  always_comb begin
    ac_ext = LW'(active_count_r);
    if (ac_ext == '0) begin
      live_last = '0;
    end else if (ac_ext > LW'(MAX_PROCS)) begin
      live_last = LW'(MAX_PROCS - 1);
    end else begin
      live_last = ac_ext - LW'(1);
    end
    last_idx = IW'(live_last);
    for (int i = 0; i < MAX_PROCS; i++) begin
      act_mask[i] = (LW'(i) <= live_last);
    end
    all_done_now = &(done_r | ~act_mask);
  end

  logic [TIME_BITS-1:0] time_inc;
  assign time_inc = (time_r == '1) ? time_r : time_r + TIME_BITS'(1);

  logic in_acc;
  logic out_free;
  assign in_acc   = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;
  assign in_stall = (state_r != ST_IDLE);

  // slot memory
  logic        mem_wr_en;
  logic [IW-1:0] mem_wr_addr;
  slot_entry_t mem_wr_data;
  logic        mem_rd_en;
  slot_entry_t rd_data;

  srtf_slot_ram #(
    .DEPTH(MAX_PROCS)
  ) u_ram (
    .clk    (clk),
    .wr_en  (mem_wr_en),
    .wr_addr(mem_wr_addr),
    .wr_data(mem_wr_data),
    .rd_en  (mem_rd_en),
    .rd_addr(issue_idx_r),
    .rd_data(rd_data)
  );

  logic          in_scan;
  logic          in_sweep;
  logic          cand_ready;
  logic          take;
  logic [FieldW-1:0] rem_new;
  logic [CW-1:0] ct_ext;
  logic [CW-1:0] tat_calc;
  logic [CW-1:0] wt_calc;
  logic          load_ok;

  always_comb begin
    in_scan    = (state_r == ST_SCAN) || (state_r == ST_LAST);
    in_sweep   = (state_r == ST_SWEEP) || (state_r == ST_SWEEP_END);
    cand_ready = (CW'(rd_data.arrival) <= CW'(time_r)) && !done_r[rd_idx_r];
    take       = in_scan && rd_vld_r && cand_ready &&
                 (!found_r || (rd_data.remaining < best_rem_r));
    rem_new    = best_rem_r - FieldW'(best_rem_r != '0);
    ct_ext     = CW'(time_inc);
    tat_calc   = (ct_ext >= CW'(best_arr_r)) ? ct_ext - CW'(best_arr_r) : '0;
    wt_calc    = (res_tat_r >= CW'(res_bur_r)) ? res_tat_r - CW'(res_bur_r) : '0;
    load_ok    = in_acc && (in_cmd == CMD_LOAD) && (32'(in_slot) < MAX_PROCS);
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          unique case (in_cmd)
            CMD_TICK:    state_nxt = all_done_now ? ST_EMIT : ST_SCAN;
            CMD_RESTART: state_nxt = ST_SWEEP;
            default:     state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_SCAN:      if (issue_idx_r == last_idx) state_nxt = ST_LAST;
      ST_LAST:      state_nxt = ST_UPDATE;
      ST_UPDATE:    state_nxt = ST_EMIT;
      ST_SWEEP:     if (issue_idx_r == IW'(MAX_PROCS - 1)) state_nxt = ST_SWEEP_END;
      ST_SWEEP_END: state_nxt = ST_IDLE;
      ST_EMIT:      if (out_free) state_nxt = ST_IDLE;
      default:      state_nxt = ST_IDLE;
    endcase
  end

  // memory port control
  always_comb begin
    mem_rd_en   = (state_r == ST_SCAN) || (state_r == ST_SWEEP);
    mem_wr_en   = 1'b0;
    mem_wr_addr = rd_idx_r;
    mem_wr_data = rd_data;
    if (load_ok) begin
      mem_wr_en             = 1'b1;
      mem_wr_addr           = IW'(in_slot);
      mem_wr_data.arrival   = in_arrival;
      mem_wr_data.burst     = in_burst;
      mem_wr_data.remaining = in_burst;
    end else if (in_sweep && rd_vld_r) begin
      // reload remaining time from burst
      mem_wr_en             = 1'b1;
      mem_wr_data.remaining = rd_data.burst;
    end else if ((state_r == ST_UPDATE) && found_r) begin
      mem_wr_en             = 1'b1;
      mem_wr_addr           = best_idx_r;
      mem_wr_data.arrival   = best_arr_r;
      mem_wr_data.burst     = best_bur_r;
      mem_wr_data.remaining = rem_new;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= ST_IDLE;
      active_count_r <= CountW'(1);
      time_r         <= '0;
      done_r         <= '0;
      rd_vld_r       <= 1'b0;
      found_r        <= 1'b0;
      out_valid_r    <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      rd_vld_r <= mem_rd_en;
      if (psel && penable && pwrite && (paddr[2] == REG_ACTIVE_COUNT)) begin
        active_count_r <= pwdata[CountW-1:0];
      end
      if (in_acc && (in_cmd == CMD_RESTART)) begin
        time_r <= '0;
        done_r <= '0;
      end
      if (in_acc && (in_cmd == CMD_TICK)) begin
        found_r <= 1'b0;
      end else if (take) begin
        found_r <= 1'b1;
      end
      if (state_r == ST_UPDATE) begin
        time_r <= time_inc;
        if (found_r && (rem_new == '0)) begin
          done_r[best_idx_r] <= 1'b1;
        end
      end
      if ((state_r == ST_EMIT) && out_free) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    rd_idx_r <= issue_idx_r;
    if (state_r == ST_IDLE) begin
      issue_idx_r <= '0;
    end else if (mem_rd_en) begin
      issue_idx_r <= issue_idx_r + IW'(1);
    end

    if (take) begin
      best_idx_r <= rd_idx_r;
      best_arr_r <= rd_data.arrival;
      best_bur_r <= rd_data.burst;
      best_rem_r <= rd_data.remaining;
    end

    if (in_acc && (in_cmd == CMD_TICK)) begin
      // every tick starts idle with zero figures, as an all-done tick reports
      res_idle_r <= 1'b1;
      res_proc_r <= '0;
      res_fin_r  <= 1'b0;
      res_ct_r   <= '0;
      res_tat_r  <= '0;
      res_bur_r  <= '0;
    end else if ((state_r == ST_UPDATE) && found_r) begin
      res_idle_r <= 1'b0;
      res_proc_r <= best_idx_r;
      if (rem_new == '0) begin
        res_fin_r <= 1'b1;
        res_ct_r  <= FieldW'(time_inc);
        res_tat_r <= tat_calc;
        res_bur_r <= best_bur_r;
      end
    end

    if ((state_r == ST_EMIT) && out_free) begin
      out_idle_r     <= res_idle_r;
      out_proc_r     <= 4'(res_proc_r);
      out_fin_r      <= res_fin_r;
      out_ct_r       <= res_ct_r;
      out_tat_r      <= FieldW'(res_tat_r);
      out_wt_r       <= FieldW'(wt_calc);
      out_all_done_r <= all_done_now;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_idle            = out_idle_r;
  assign out_proc_index      = out_proc_r;
  assign out_finished        = out_fin_r;
  assign out_completion_time = out_ct_r;
  assign out_turnaround      = out_tat_r;
  assign out_waiting         = out_wt_r;
  assign out_all_done        = out_all_done_r;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_ACTIVE_COUNT) ? CfgDataW'(active_count_r) : '0;

endmodule

// ===== sim/tb_srtf_tick_scheduler.sv =====
// Self-checking testbench for the SRTF tick scheduler: directed and random command streams.
module tb_srtf_tick_scheduler;
  timeunit 1ns;
  timeprecision 1ps;
  import srtf_pkg::*;

  localparam int CLK_HALF      = 5;
  localparam int CYCLE_LIMIT   = 3_000_000;
  localparam int SETTLE_CYCLES = 32;
  localparam int RANDOM_ITEMS  = 440;
  localparam int MAX_SLOTS     = MaxProcsDef;
  localparam int PRINT_CAP     = 40;

  localparam logic [1:0]          CMD_UNUSED        = 2'd3;
  localparam logic [CfgAddrW-1:0] ACTIVE_COUNT_ADDR = CfgAddrW'(REG_ACTIVE_COUNT) << 2;
  localparam logic [FieldW-1:0]   TIME_TOP          = '1;

  typedef struct packed {
    logic              idle;
    logic [3:0]        proc_index;
    logic              finished;
    logic [FieldW-1:0] completion_time;
    logic [FieldW-1:0] turnaround;
    logic [FieldW-1:0] waiting;
    logic              all_done;
  } tick_result_t;

  logic                clk;
  logic                rst_n;
  logic                in_valid;
  logic                in_stall;
  logic [1:0]          in_cmd;
  logic [3:0]          in_slot;
  logic [FieldW-1:0]   in_arrival;
  logic [FieldW-1:0]   in_burst;
  logic                out_valid;
  logic                out_stall;
  logic                out_idle;
  logic [3:0]          out_proc_index;
  logic                out_finished;
  logic [FieldW-1:0]   out_completion_time;
  logic [FieldW-1:0]   out_turnaround;
  logic [FieldW-1:0]   out_waiting;
  logic                out_all_done;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [CfgAddrW-1:0] paddr;
  logic [CfgDataW-1:0] pwdata;
  logic [CfgDataW-1:0] prdata;
  logic                pready;

  srtf_tick_scheduler DUT (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_cmd              (in_cmd),
    .in_slot             (in_slot),
    .in_arrival          (in_arrival),
    .in_burst            (in_burst),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_idle            (out_idle),
    .out_proc_index      (out_proc_index),
    .out_finished        (out_finished),
    .out_completion_time (out_completion_time),
    .out_turnaround      (out_turnaround),
    .out_waiting         (out_waiting),
    .out_all_done        (out_all_done),
    .psel                (psel),
    .penable             (penable),
    .pwrite              (pwrite),
    .paddr               (paddr),
    .pwdata              (pwdata),
    .prdata              (prdata),
    .pready              (pready)
  );

  // Scheduler state as the testbench tracks it
  logic [FieldW-1:0] slot_arrival [MAX_SLOTS];
  logic [FieldW-1:0] slot_burst   [MAX_SLOTS];
  logic [FieldW-1:0] slot_left    [MAX_SLOTS];
  logic              slot_done    [MAX_SLOTS];
  logic [FieldW-1:0] sched_time;
  logic [CountW-1:0] active_cfg;

  tick_result_t pending_results[$];

  int  mismatches      = 0;
  int  useful_beats    = 0;
  int  ignored_beats   = 0;
  int  results_checked = 0;
  int  completions     = 0;
  int  idle_results    = 0;
  int  cycles          = 0;
  int  stall_left      = 0;
  int  schedules_run   = 0;
  bit  gaps_on         = 1'b1;

  initial begin
    clk = 1'b0;
    forever #CLK_HALF clk = ~clk;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("srtf_tick_scheduler verification failed");
      $finish;
    end
  end

  function automatic int live_slots();
    if (active_cfg == 0) return 1;
    if (active_cfg > MAX_SLOTS) return MAX_SLOTS;
    return int'(active_cfg);
  endfunction

  function automatic logic all_active_done();
    int live;
    live = live_slots();
    for (int i = 0; i < live; i++)
      if (!slot_done[i]) return 1'b0;
    return 1'b1;
  endfunction

  // Apply one accepted command to the tracked state; queue the tick result.
  task automatic advance_schedule(input logic [1:0] cmd, input logic [3:0] slot,
                                  input logic [FieldW-1:0] arr,
                                  input logic [FieldW-1:0] bur);
    tick_result_t      res;
    int                live;
    int                pick;
    logic              found;
    logic [FieldW-1:0] best;
    logic [FieldW-1:0] tat;
    res = '0;
    case (cmd)
      CMD_LOAD: begin
        slot_arrival[slot] = arr;
        slot_burst[slot]   = bur;
        slot_left[slot]    = bur;
      end
      CMD_RESTART: begin
        for (int i = 0; i < MAX_SLOTS; i++) begin
          slot_left[i] = slot_burst[i];
          slot_done[i] = 1'b0;
        end
        sched_time = '0;
      end
      CMD_TICK: begin
        if (all_active_done()) begin
          res.idle     = 1'b1;
          res.all_done = 1'b1;
        end else begin
          live  = live_slots();
          found = 1'b0;
          pick  = 0;
          best  = '0;
          for (int i = 0; i < live; i++) begin
            if (slot_arrival[i] <= sched_time && !slot_done[i] &&
                (!found || slot_left[i] < best)) begin
              found = 1'b1;
              best  = slot_left[i];
              pick  = i;
            end
          end
          if (sched_time != TIME_TOP) sched_time++;
          if (!found) begin
            res.idle = 1'b1;
          end else begin
            res.proc_index = 4'(pick);
            if (slot_left[pick] != 0) slot_left[pick]--;
            if (slot_left[pick] == 0) begin
              tat = (sched_time >= slot_arrival[pick]) ? sched_time - slot_arrival[pick] : '0;
              slot_done[pick]     = 1'b1;
              res.finished        = 1'b1;
              res.completion_time = sched_time;
              res.turnaround      = tat;
              res.waiting         = (tat >= slot_burst[pick]) ? tat - slot_burst[pick] : '0;
            end
          end
          res.all_done = all_active_done();
        end
        pending_results.push_back(res);
      end
      default: ;
    endcase
  endtask

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    if (mismatches < PRINT_CAP)
      $display("%0t ns: %s got 0x%0h, expected 0x%0h", $time, what, got, want);
    mismatches++;
  endtask

  task automatic check_field(input string what, input logic [FieldW-1:0] got,
                             input logic [FieldW-1:0] want);
    if (got !== want) report_mismatch(what, 32'(got), 32'(want));
  endtask

  // Receiver stall: random bursts while gaps are enabled
  always @(negedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else if (gaps_on && $urandom_range(0, 9) == 0) begin
      stall_left = $urandom_range(1, 16) - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin : result_check
    tick_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result beat with no tick pending", 32'(out_proc_index), 0);
      end else begin
        want = pending_results.pop_front();
        check_field("idle", FieldW'(out_idle), FieldW'(want.idle));
        check_field("proc_index", FieldW'(out_proc_index), FieldW'(want.proc_index));
        check_field("finished", FieldW'(out_finished), FieldW'(want.finished));
        check_field("completion_time", out_completion_time, want.completion_time);
        check_field("turnaround", out_turnaround, want.turnaround);
        check_field("waiting", out_waiting, want.waiting);
        check_field("all_done", FieldW'(out_all_done), FieldW'(want.all_done));
        results_checked++;
        if (want.finished) completions++;
        if (want.idle) idle_results++;
      end
    end
  end

  // Drive one command beat; return at the edge that accepts it, valid left high.
  task automatic send_beat(input logic [1:0] cmd, input logic [3:0] slot,
                           input logic [FieldW-1:0] arr, input logic [FieldW-1:0] bur);
    @(negedge clk);
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(negedge clk);
    end
    in_valid   <= 1'b1;
    in_cmd     <= cmd;
    in_slot    <= slot;
    in_arrival <= arr;
    in_burst   <= bur;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    advance_schedule(cmd, slot, arr, bur);
    if (cmd == CMD_UNUSED) ignored_beats++;
    else useful_beats++;
  endtask

  task automatic load_slot(input int slot, input int arr, input int bur);
    send_beat(CMD_LOAD, 4'(slot), FieldW'(arr), FieldW'(bur));
  endtask

  task automatic run_tick();
    send_beat(CMD_TICK, 4'($urandom), FieldW'($urandom), FieldW'($urandom_range(1, 65535)));
  endtask

  task automatic restart_schedule();
    send_beat(CMD_RESTART, 4'($urandom), FieldW'($urandom), FieldW'($urandom_range(1, 65535)));
  endtask

  // Tick until every active slot is done, then once more for the all-done report.
  task automatic tick_to_completion(input int guard);
    int n;
    n = 0;
    while (!all_active_done() && n < guard) begin
      run_tick();
      n++;
    end
    run_tick();
  endtask

  // Drop valid and hold off until every tick result is back and the block settles.
  task automatic wait_for_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Write active_count, then read it back. Call only while the block is idle.
  task automatic write_active_count(input logic [CountW-1:0] value);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ACTIVE_COUNT_ADDR;
    pwdata  <= CfgDataW'(value);
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    active_cfg = value;
    @(negedge clk);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    check_field("active_count readback", FieldW'(prdata[CountW-1:0]), FieldW'(value));
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Field extremes; every slot gets defined contents before any scan.
  task automatic test_load_extremes();
    load_slot(0, 0, 1);
    load_slot(15, 16'hFFFF, 16'hFFFF);
    load_slot(1, 16'hAAAA, 16'h5555);
    load_slot(2, 16'h5555, 16'hAAAA);
    for (int i = 3; i < 15; i++)
      load_slot(i, $urandom, $urandom_range(1, 65535));
  endtask

  // One slot at reset count: completion, all-done ticks, unknown command,
  // restart, and a reload of a finished slot that keeps it finished.
  task automatic test_single_slot();
    run_tick();
    run_tick();
    send_beat(CMD_UNUSED, 4'd0, '0, 16'd1);
    restart_schedule();
    run_tick();
    load_slot(0, 0, 2);
    run_tick();
  endtask

  // Late arrivals give idle ticks; a shorter job preempts; equal remaining
  // time goes to the lower slot.
  task automatic test_preemption();
    wait_for_results();
    write_active_count(CountW'(3));
    load_slot(0, 2, 3);
    load_slot(1, 3, 1);
    load_slot(2, 3, 1);
    restart_schedule();
    tick_to_completion(20);
  endtask

  task automatic run_random_schedule();
    logic [CountW-1:0] cfg;
    int                pick;
    int                live;
    int                guard;
    pick = $urandom_range(0, 19);
    if (pick == 0) cfg = '0;
    else if (pick == 1) cfg = CountW'($urandom_range(MAX_SLOTS + 1, 31));
    else if (pick <= 3) cfg = CountW'(MAX_SLOTS);
    else cfg = CountW'($urandom_range(1, 6));
    wait_for_results();
    write_active_count(cfg);
    gaps_on = ($urandom_range(0, 3) != 0);
    live = live_slots();
    for (int i = 0; i < live; i++)
      load_slot(i, $urandom_range(0, 12), $urandom_range(1, (live > 8) ? 3 : 8));
    // full-range contents into a slot that sits out this schedule
    if (live < MAX_SLOTS && $urandom_range(0, 1) == 1)
      load_slot($urandom_range(live, MAX_SLOTS - 1), $urandom, $urandom_range(1, 65535));
    restart_schedule();
    guard = 0;
    while (!all_active_done() && guard < 300) begin
      pick = $urandom_range(0, 39);
      if (pick == 0)
        send_beat(CMD_UNUSED, 4'($urandom), FieldW'($urandom), FieldW'($urandom_range(1, 65535)));
      else if (pick == 1)
        load_slot($urandom_range(0, live - 1), $urandom_range(0, 20), $urandom_range(1, 4));
      else if (pick == 2 && guard < 60)
        restart_schedule();
      else
        run_tick();
      guard++;
    end
    repeat ($urandom_range(1, 2)) run_tick();
    schedules_run++;
  endtask

  task automatic test_random_schedules();
    int start;
    start = useful_beats;
    while (useful_beats - start < RANDOM_ITEMS) run_random_schedule();
  endtask

  // Idle ticks advance time until a late job arrives, then it runs to the
  // end back to back with no gaps on either side.
  task automatic test_late_arrival();
    wait_for_results();
    gaps_on = 1'b0;
    write_active_count(CountW'(1));
    load_slot(0, 20, 3);
    restart_schedule();
    tick_to_completion(40);
  endtask

  initial begin
    rst_n      = 1'b0;
    in_valid   = 1'b0;
    in_cmd     = CMD_LOAD;
    in_slot    = '0;
    in_arrival = '0;
    in_burst   = '0;
    out_stall  = 1'b0;
    psel       = 1'b0;
    penable    = 1'b0;
    pwrite     = 1'b0;
    paddr      = '0;
    pwdata     = '0;
    sched_time = '0;
    active_cfg = CountW'(1);
    for (int i = 0; i < MAX_SLOTS; i++) begin
      slot_arrival[i] = '0;
      slot_burst[i]   = '0;
      slot_left[i]    = '0;
      slot_done[i]    = 1'b0;
    end
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_load_extremes();
    test_single_slot();
    test_preemption();
    test_random_schedules();
    test_late_arrival();

    wait_for_results();
    $display("Sent %0d command beats (%0d unknown) over %0d random schedules.",
             useful_beats + ignored_beats, ignored_beats, schedules_run);
    $display("Checked %0d tick results: %0d completions, %0d idle; %0d mismatches.",
             results_checked, completions, idle_results, mismatches);
    if (mismatches == 0) begin
      $display("srtf_tick_scheduler verification clean");
    end else begin
      $display("srtf_tick_scheduler verification failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
sv/srtf_pkg.sv
sv/srtf_slot_ram.sv
sv/srtf_tick_scheduler.sv
sim/tb_srtf_tick_scheduler.sv
